[hdl/sckst_pkg.sv]
// Shared types and constants for the scan code key state tracker.
// No dependencies; imported by every module of the block.
package sckst_pkg;

  localparam int KEY_W       = 7;
  localparam int CODE_W      = 8;
  localparam int CNT_W       = 8;
  localparam int ACT_W       = 3;
  localparam int KCNT_W      = 3;
  localparam int MODE_W      = 2;
  localparam int CHORD_SLOTS = 4;
  localparam int IDX_W       = 8;

  localparam logic [CODE_W-1:0] PREFIX_CODE = 8'hE0;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 8'hFF;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 8'd10;

  typedef enum logic [ACT_W-1:0] {
    ACT_SCAN         = 3'd0,
    ACT_FRAME        = 3'd1,
    ACT_TAKE_PRESS   = 3'd2,
    ACT_TAKE_RELEASE = 3'd3,
    ACT_CHORD        = 3'd4,
    ACT_CLEAR        = 3'd5
  } action_e;

  localparam logic [MODE_W-1:0] MODE_ALL_HELD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HELD_OR_NEW = 2'd1;

  typedef struct packed {
    action_e                               action;
    logic [CODE_W-1:0]                     code;
    logic [CHORD_SLOTS-1:0][KEY_W-1:0]     key;
    logic [KCNT_W-1:0]                     key_count;
    logic [MODE_W-1:0]                     chord_mode;
  } item_t;

  typedef struct packed {
    logic                   take_ok;
    logic                   held_sel;
    logic                   held_nxt;
    logic [CHORD_SLOTS-1:0] slot_held;
    logic [CHORD_SLOTS-1:0] slot_frame;
  } cell_rpt_t;

  typedef struct packed {
    logic any_held;
    logic key_held;
    logic hit;
  } result_t;

endpackage

[hdl/sckst_key_cell.sv]
// One per-key state cell: held flag, press/release counters, pending and frame flags.
// Depends on sckst_pkg.
module sckst_key_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  sckst_pkg::item_t          item_i,
  input  logic [7:0]                limit_i,
  output sckst_pkg::cell_rpt_t      rpt_o
);
  import sckst_pkg::*;

  localparam logic [IDX_W-1:0] IDX = IDX_W'(CELL_IDX);

  logic             held_q, held_d;
  logic             pend_q, pend_d;
  logic             frame_q, frame_d;
  logic [CNT_W-1:0] press_q, press_d;
  logic [CNT_W-1:0] rel_q, rel_d;
  logic             sel0, code_sel;

  assign sel0     = ({1'b0, item_i.key[0]} == IDX);
  assign code_sel = ({1'b0, item_i.code[KEY_W-1:0]} == IDX) && (item_i.code != PREFIX_CODE);

  always_comb begin
    held_d  = held_q;
    pend_d  = pend_q;
    frame_d = frame_q;
    press_d = press_q;
    rel_d   = rel_q;
    if (accept_i) begin
      unique case (item_i.action)
        ACT_SCAN: begin
          if (code_sel) begin
            if (!item_i.code[CODE_W-1]) begin
              if (!held_q) begin
                if (press_q != CNT_MAX) press_d = press_q + 8'd1;
                pend_d = 1'b1;
              end
              held_d = 1'b1;
            end else begin
              held_d = 1'b0;
              if (rel_q != CNT_MAX) rel_d = rel_q + 8'd1;
            end
          end
        end
        ACT_FRAME: begin
          frame_d = pend_q;
          pend_d  = 1'b0;
          if (press_q > limit_i) press_d = '0;
          rel_d = '0;
        end
        ACT_TAKE_PRESS: begin
          if (sel0 && press_q != '0) press_d = press_q - 8'd1;
        end
        ACT_TAKE_RELEASE: begin
          if (sel0 && rel_q != '0) rel_d = rel_q - 8'd1;
        end
        ACT_CHORD: begin
        end
        ACT_CLEAR: begin
          press_d = '0;
          rel_d   = '0;
          pend_d  = 1'b0;
          frame_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rpt_o.take_ok  = sel0 && (((item_i.action == ACT_TAKE_PRESS) && (press_q != '0)) ||
                              ((item_i.action == ACT_TAKE_RELEASE) && (rel_q != '0)));
    rpt_o.held_nxt = held_d;
    rpt_o.held_sel = sel0 & held_d;
    for (int j = 0; j < CHORD_SLOTS; j++) begin
      rpt_o.slot_held[j]  = ({1'b0, item_i.key[j]} == IDX) & held_q;
      rpt_o.slot_frame[j] = ({1'b0, item_i.key[j]} == IDX) & frame_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      pend_q  <= 1'b0;
      frame_q <= 1'b0;
      press_q <= '0;
      rel_q   <= '0;
    end else begin
      held_q  <= held_d;
      pend_q  <= pend_d;
      frame_q <= frame_d;
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

endmodule

[hdl/sckst_merge.sv]
// Combines the reports of all key cells into one result: consume outcome, chord test,
// key0 held flag and the any-held flag. Depends on sckst_pkg.
module sckst_merge #(
  parameter int NUM_KEYS  = 128,
  parameter int MAX_CHORD = 4
) (
  input  sckst_pkg::item_t     item_i,
  input  sckst_pkg::cell_rpt_t rpt_i [NUM_KEYS],
  output sckst_pkg::result_t   res_o
);
  import sckst_pkg::*;

  localparam int SLOTS_USED = (MAX_CHORD < CHORD_SLOTS) ? MAX_CHORD : CHORD_SLOTS;

  logic                   take_any, held_key, held_any;
  logic [CHORD_SLOTS-1:0] slot_h, slot_f;
  logic [KCNT_W-1:0]      n_eff;
  logic                   all_held, all_ok, any_new, chord_hit;

  always_comb begin
    take_any = 1'b0;
    held_key = 1'b0;
    held_any = 1'b0;
    slot_h   = '0;
    slot_f   = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      take_any = take_any | rpt_i[i].take_ok;
      held_key = held_key | rpt_i[i].held_sel;
      held_any = held_any | rpt_i[i].held_nxt;
      slot_h   = slot_h | rpt_i[i].slot_held;
      slot_f   = slot_f | rpt_i[i].slot_frame;
    end
  end

  always_comb begin
    n_eff = (item_i.key_count > KCNT_W'(SLOTS_USED)) ? KCNT_W'(SLOTS_USED) : item_i.key_count;
    all_held = 1'b1;
    all_ok   = 1'b1;
    any_new  = 1'b0;
    for (int j = 0; j < CHORD_SLOTS; j++) begin
      if (KCNT_W'(j) < n_eff) begin
        all_held = all_held & slot_h[j];
        all_ok   = all_ok & (slot_h[j] | slot_f[j]);
        any_new  = any_new | slot_f[j];
      end
    end
    if (item_i.chord_mode == MODE_ALL_HELD) chord_hit = all_held;
    else if (item_i.chord_mode == MODE_HELD_OR_NEW) chord_hit = all_ok;
    else chord_hit = all_ok & any_new;
  end

  always_comb begin
    unique case (item_i.action)
      ACT_TAKE_PRESS, ACT_TAKE_RELEASE: res_o.hit = take_any;
      ACT_CHORD:                        res_o.hit = chord_hit;
      default:                          res_o.hit = 1'b0;
    endcase
    res_o.key_held = held_key;
    res_o.any_held = held_any;
  end

endmodule

[hdl/scan_code_key_state_tracker_unit.sv]
// Top level of the scan code key state tracker: key cell array, merge and output buffer.
// Depends on sckst_pkg, sckst_key_cell and sckst_merge.
//
// Takes one beat per clock cycle unless the output buffer is full. Every key has its own
// cell of flops, so a scan code, frame tick, consume, chord check or clear is applied to
// the whole table in the cycle the beat is accepted, and its result beat is registered.
// A two-entry output buffer lets a further beat in while one result waits to be taken.
// press_keep_limit is written through cfg_we_i/cfg_wdata_i and resets to 10.
module scan_code_key_state_tracker_unit #(
  parameter int NUM_KEYS  = 128,
  parameter int MAX_CHORD = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[2:0] code[10:3] key0[17:11] key1[24:18] key2[31:25] key3[38:32]
  // key_count[41:39] chord_mode[43:42], zero fill [47:44]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hit[0] key_held[1] any_held[2], zero fill [7:3]
  output logic [7:0]  m_axis_tdata_o
);
  import sckst_pkg::*;

  logic [CNT_W-1:0] limit_q;
  item_t            item;
  logic             accept;
  cell_rpt_t        rpt [NUM_KEYS];
  result_t          res;
  result_t          out_q, skid_q;
  logic             out_vld_q, skid_vld_q;
  logic             pop;

  assign item.action     = action_e'(s_axis_tdata_i[2:0]);
  assign item.code       = s_axis_tdata_i[10:3];
  assign item.key[0]     = s_axis_tdata_i[17:11];
  assign item.key[1]     = s_axis_tdata_i[24:18];
  assign item.key[2]     = s_axis_tdata_i[31:25];
  assign item.key[3]     = s_axis_tdata_i[38:32];
  assign item.key_count  = s_axis_tdata_i[41:39];
  assign item.chord_mode = s_axis_tdata_i[43:42];

  assign s_axis_tready_o = !skid_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_vld_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
    sckst_key_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .accept_i(accept),
      .item_i  (item),
      .limit_i (limit_q),
      .rpt_o   (rpt[g])
    );
  end

  sckst_merge #(
    .NUM_KEYS (NUM_KEYS),
    .MAX_CHORD(MAX_CHORD)
  ) u_merge (
    .item_i(item),
    .rpt_i (rpt),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= accept;
        end
      end else if (accept) begin
        if (!out_vld_q) out_vld_q <= 1'b1;
        else skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (accept) out_q <= res;
    end else if (accept) begin
      if (!out_vld_q) out_q <= res;
      else skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, out_q.any_held, out_q.key_held, out_q.hit};

endmodule
